// ===== hw/rtl/flvp_pkg.sv =====
package flvp_pkg;

  // Stream layout
  localparam logic [23:0] FILE_HDR_LEN = 24'd13;  // file header plus first size word
  localparam logic [23:0] TAG_HDR_LEN  = 24'd11;
  localparam logic [23:0] TRAIL_LEN    = 24'd4;

  // Tag type and codec codes
  localparam logic [7:0] TAG_AUDIO = 8'd8;
  localparam logic [7:0] TAG_VIDEO = 8'd9;
  localparam logic [3:0] CODEC_AVC = 4'd7;

  // Media kind codes
  localparam logic [1:0] KIND_AUDIO = 2'd0;
  localparam logic [1:0] KIND_VIDEO = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;

  localparam int QUEUE_DEPTH_DEF = 2;

  // Raw tag record passed from the parser to the formatter
  typedef struct packed {
    logic [31:0] tag_number;
    logic [7:0]  tag_type;
    logic [23:0] size;
    logic [31:0] stamp;
    logic        have_flags;
    logic [7:0]  flags;
    logic [7:0]  avc;
  } rec_t;

  // Decoded result record
  typedef struct packed {
    logic [31:0] tag_number;
    logic [7:0]  tag_kind_code;
    logic [23:0] payload_size;
    logic [31:0] time_stamp;
    logic [24:0] total_tag_size;
    logic [1:0]  media_kind;
    logic [3:0]  codec_id;
    logic [1:0]  audio_rate_code;
    logic        audio_sample_wide;
    logic        audio_stereo;
    logic [3:0]  video_frame_type;
    logic [7:0]  avc_packet_type;
  } out_rec_t;

endpackage

// ===== hw/rtl/flv_tag_header_parser.sv =====
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_ready    data_byte, stream_start
// out_     output     out_valid/out_ready  one decoded record per tag
//
// One byte is taken every cycle while the record queue has room; the byte
// parser updates only counters and header registers, so nothing else limits it.
// A record passes through the queue and then the output register before out_valid.
// rst_n is synchronous, active low; there is no clearing pass after reset.
// A stalled output holds its register; the queue (QUEUE_DEPTH records) lets
// the parser keep taking bytes until it fills, then in_ready drops.
module flv_tag_header_parser #(
  parameter int QUEUE_DEPTH = flvp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_tag_number,
  output logic [7:0]  out_tag_kind_code,
  output logic [23:0] out_payload_size,
  output logic signed [31:0] out_time_stamp,
  output logic [24:0] out_total_tag_size,
  output logic [1:0]  out_media_kind,
  output logic [3:0]  out_codec_id,
  output logic [1:0]  out_audio_rate_code,
  output logic        out_audio_sample_wide,
  output logic        out_audio_stereo,
  output logic [3:0]  out_video_frame_type,
  output logic [7:0]  out_avc_packet_type
);

  logic               byte_accept, rec_push, q_full, q_valid, q_pop;
  flvp_pkg::rec_t     push_rec, pop_rec;
  flvp_pkg::out_rec_t out_rec;

  assign in_ready    = !q_full;
  assign byte_accept = in_valid && in_ready;

  flvp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_accept  (byte_accept),
    .data_byte    (in_data_byte),
    .stream_start (in_stream_start),
    .rec_push     (rec_push),
    .rec          (push_rec)
  );

  flvp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_rec   (pop_rec)
  );

  flvp_format u_format (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (q_valid),
    .rec       (pop_rec),
    .rec_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rec   (out_rec)
  );

  assign out_tag_number        = out_rec.tag_number;
  assign out_tag_kind_code     = out_rec.tag_kind_code;
  assign out_payload_size      = out_rec.payload_size;
  assign out_time_stamp        = out_rec.time_stamp;
  assign out_total_tag_size    = out_rec.total_tag_size;
  assign out_media_kind        = out_rec.media_kind;
  assign out_codec_id          = out_rec.codec_id;
  assign out_audio_rate_code   = out_rec.audio_rate_code;
  assign out_audio_sample_wide = out_rec.audio_sample_wide;
  assign out_audio_stereo      = out_rec.audio_stereo;
  assign out_video_frame_type  = out_rec.video_frame_type;
  assign out_avc_packet_type   = out_rec.avc_packet_type;

endmodule

// ===== hw/rtl/flvp_parser.sv =====
module flvp_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_accept,
  input  logic [7:0]      data_byte,
  input  logic            stream_start,
  output logic            rec_push,
  output flvp_pkg::rec_t  rec
);

  typedef enum logic [5:0] {
    PH_FILE  = 6'b000001,
    PH_HDR   = 6'b000010,
    PH_FLAGS = 6'b000100,
    PH_AVC   = 6'b001000,
    PH_SKIP  = 6'b010000,
    PH_TRAIL = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [23:0] cnt_r, cnt_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [23:0] size_r, size_nxt;
  logic [31:0] stamp_r, stamp_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [31:0] tcnt_r, tcnt_nxt;

  phase_t      ph;
  logic [23:0] cnt, idx, cnt_inc, remain;
  logic [7:0]  typ, flg;
  logic [23:0] siz;
  logic [31:0] stamp, tcnt;
  logic        emit, have_flags;
  logic [7:0]  emit_flags, emit_avc;

  always_comb begin
    // start of stream: parse this byte from a clean state
    ph    = stream_start ? PH_FILE : phase_r;
    cnt   = stream_start ? '0 : cnt_r;
    typ   = stream_start ? '0 : type_r;
    siz   = stream_start ? '0 : size_r;
    stamp = stream_start ? '0 : stamp_r;
    flg   = stream_start ? '0 : flag_r;
    tcnt  = stream_start ? '0 : tcnt_r;

    phase_nxt  = ph;
    cnt_nxt    = cnt;
    type_nxt   = typ;
    size_nxt   = siz;
    stamp_nxt  = stamp;
    flag_nxt   = flg;
    emit       = 1'b0;
    have_flags = 1'b0;
    emit_flags = '0;
    emit_avc   = '0;
    cnt_inc    = cnt + 24'd1;
    remain     = '0;
    idx        = '0;

    unique case (ph)
      PH_FILE: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= flvp_pkg::FILE_HDR_LEN) begin
          phase_nxt = PH_HDR;
          cnt_nxt   = '0;
        end
      end
      PH_FLAGS: begin
        flag_nxt = data_byte;
        if (typ == flvp_pkg::TAG_VIDEO && data_byte[3:0] == flvp_pkg::CODEC_AVC &&
            siz >= 24'd2) begin
          phase_nxt = PH_AVC;
        end else begin
          emit       = 1'b1;
          have_flags = 1'b1;
          emit_flags = data_byte;
          remain     = siz - 24'd1;
          cnt_nxt    = remain;
          phase_nxt  = (remain != '0) ? PH_SKIP : PH_TRAIL;
        end
      end
      PH_AVC: begin
        emit       = 1'b1;
        have_flags = 1'b1;
        emit_flags = flg;
        emit_avc   = data_byte;
        remain     = siz - 24'd2;
        cnt_nxt    = remain;
        phase_nxt  = (remain != '0) ? PH_SKIP : PH_TRAIL;
      end
      PH_SKIP: begin
        cnt_nxt = cnt - 24'd1;
        if (cnt_nxt == '0) begin
          phase_nxt = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= flvp_pkg::TRAIL_LEN) begin
          phase_nxt = PH_HDR;
          cnt_nxt   = '0;
        end
      end
      default: begin
        // tag header; a stray phase restarts the header at this byte
        idx = (ph == PH_HDR) ? cnt : '0;
        priority if (idx == 24'd0) begin
          type_nxt  = data_byte;
          size_nxt  = '0;
          stamp_nxt = '0;
          flag_nxt  = '0;
        end else if (idx == 24'd1) begin
          size_nxt[23:16] = data_byte;
        end else if (idx == 24'd2) begin
          size_nxt[15:8] = data_byte;
        end else if (idx == 24'd3) begin
          size_nxt[7:0] = data_byte;
        end else if (idx == 24'd4) begin
          stamp_nxt[23:16] = data_byte;
        end else if (idx == 24'd5) begin
          stamp_nxt[15:8] = data_byte;
        end else if (idx == 24'd6) begin
          stamp_nxt[7:0] = data_byte;
        end else if (idx == 24'd7) begin
          stamp_nxt[31:24] = data_byte;
        end else begin
          // stream id bytes: drop
        end
        cnt_nxt   = idx + 24'd1;
        phase_nxt = PH_HDR;
        if (cnt_nxt >= flvp_pkg::TAG_HDR_LEN) begin
          cnt_nxt = '0;
          if (size_nxt == '0) begin
            emit      = 1'b1;
            phase_nxt = PH_TRAIL;
          end else begin
            phase_nxt = PH_FLAGS;
          end
        end
      end
    endcase

    tcnt_nxt = emit ? tcnt + 32'd1 : tcnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FILE;
      cnt_r   <= '0;
      type_r  <= '0;
      size_r  <= '0;
      stamp_r <= '0;
      flag_r  <= '0;
      tcnt_r  <= '0;
    end else if (byte_accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      type_r  <= type_nxt;
      size_r  <= size_nxt;
      stamp_r <= stamp_nxt;
      flag_r  <= flag_nxt;
      tcnt_r  <= tcnt_nxt;
    end
  end

  assign rec_push        = byte_accept && emit;
  assign rec.tag_number  = tcnt_nxt;
  assign rec.tag_type    = type_nxt;
  assign rec.size        = size_nxt;
  assign rec.stamp       = stamp_nxt;
  assign rec.have_flags  = have_flags;
  assign rec.flags       = emit_flags;
  assign rec.avc         = emit_avc;

endmodule

// ===== hw/rtl/flvp_queue.sv =====
module flvp_queue #(
  parameter int DEPTH = flvp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  flvp_pkg::rec_t  push_rec,
  output logic            full,
  output logic            pop_valid,
  input  logic            pop,
  output flvp_pkg::rec_t  pop_rec
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  flvp_pkg::rec_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  fill_r, fill_nxt;
  logic           do_push, do_pop;

  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;
  assign full      = (fill_r == DEPTH_C);
  assign pop_valid = (fill_r != '0);
  assign pop_rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ===== hw/rtl/flvp_format.sv =====
module flvp_format (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rec_valid,
  input  flvp_pkg::rec_t     rec,
  output logic               rec_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output flvp_pkg::out_rec_t out_rec
);

  logic               valid_r, valid_nxt;
  flvp_pkg::out_rec_t out_r, dec;

  always_comb begin
    dec                   = '0;
    dec.tag_number        = rec.tag_number;
    dec.tag_kind_code     = rec.tag_type;
    dec.payload_size      = rec.size;
    dec.time_stamp        = rec.stamp;
    dec.total_tag_size    = {1'b0, rec.size} + 25'(flvp_pkg::TAG_HDR_LEN);
    dec.avc_packet_type   = rec.avc;
    priority if (rec.tag_type == flvp_pkg::TAG_AUDIO) begin
      dec.media_kind = flvp_pkg::KIND_AUDIO;
      if (rec.have_flags) begin
        dec.codec_id          = rec.flags[7:4];
        dec.audio_rate_code   = rec.flags[3:2];
        dec.audio_sample_wide = rec.flags[1];
        dec.audio_stereo      = rec.flags[0];
      end
    end else if (rec.tag_type == flvp_pkg::TAG_VIDEO) begin
      dec.media_kind = flvp_pkg::KIND_VIDEO;
      if (rec.have_flags) begin
        dec.video_frame_type = rec.flags[7:4];
        dec.codec_id         = rec.flags[3:0];
      end
    end else begin
      dec.media_kind = flvp_pkg::KIND_OTHER;
    end
  end

  // load a new record whenever the output register is empty or being drained
  assign rec_pop   = rec_valid && (!valid_r || out_ready);
  assign valid_nxt = rec_pop || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      out_r <= dec;
    end
  end

  assign out_valid = valid_r;
  assign out_rec   = out_r;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam logic [7:0]  TAG_SCRIPT  = 8'd18;
  localparam int unsigned WHOLE_TAG   = 32'hFFFF_FFFF;
  localparam int          STALL_LIMIT = 2000;
  localparam int          RANDOM_BYTES = 970;

  typedef enum logic [5:0] {
    STG_FILE_HDR = 6'b000001,
    STG_TAG_HDR  = 6'b000010,
    STG_FLAGS    = 6'b000100,
    STG_AVC      = 6'b001000,
    STG_SKIP     = 6'b010000,
    STG_TRAILER  = 6'b100000
  } stage_t;

  typedef struct {
    logic [7:0] data;
    logic       start;
    logic       wait_drain;
  } byte_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_stream_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_tag_number;
  logic [7:0]  out_tag_kind_code;
  logic [23:0] out_payload_size;
  logic signed [31:0] out_time_stamp;
  logic [24:0] out_total_tag_size;
  logic [1:0]  out_media_kind;
  logic [3:0]  out_codec_id;
  logic [1:0]  out_audio_rate_code;
  logic        out_audio_sample_wide;
  logic        out_audio_stereo;
  logic [3:0]  out_video_frame_type;
  logic [7:0]  out_avc_packet_type;

  flv_tag_header_parser dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_stream_start      (in_stream_start),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_tag_number       (out_tag_number),
    .out_tag_kind_code    (out_tag_kind_code),
    .out_payload_size     (out_payload_size),
    .out_time_stamp       (out_time_stamp),
    .out_total_tag_size   (out_total_tag_size),
    .out_media_kind       (out_media_kind),
    .out_codec_id         (out_codec_id),
    .out_audio_rate_code  (out_audio_rate_code),
    .out_audio_sample_wide(out_audio_sample_wide),
    .out_audio_stereo     (out_audio_stereo),
    .out_video_frame_type (out_video_frame_type),
    .out_avc_packet_type  (out_avc_packet_type)
  );

  always #2 clk = ~clk;

  byte_item_t          stimulus[$];
  flvp_pkg::out_rec_t  expected_records[$];
  flvp_pkg::out_rec_t  head_record;
  logic       hold_for_drain = 1'b0;
  int         bytes_taken = 0;
  int         bytes_planned = 0;
  int         mismatches = 0;
  int         stall_cycles = 0;
  logic       calm;

  // parser shadow state
  stage_t      parse_stage = STG_FILE_HDR;
  logic [23:0] stage_count = '0;
  logic [7:0]  cur_kind = '0;
  logic [23:0] cur_len = '0;
  logic [31:0] cur_stamp = '0;
  logic [7:0]  cur_flags = '0;
  logic [31:0] tags_parsed = '0;

  // no idling on either side for a stretch of the run
  assign calm = (bytes_taken >= 500) && (bytes_taken < 800);

  task automatic push_byte(input logic [7:0] data, input logic start);
    byte_item_t it;
    it.data = data;
    it.start = start;
    it.wait_drain = hold_for_drain;
    hold_for_drain = 1'b0;
    stimulus.push_back(it);
  endtask

  task automatic push_file_header();
    push_byte(8'($urandom), 1'b1);
    repeat (flvp_pkg::FILE_HDR_LEN - 1) push_byte(8'($urandom), 1'b0);
  endtask

  // Send the first cut bytes of a tag: header, payload, trailing size word.
  task automatic push_tag(input logic [7:0] kind, input logic [23:0] len,
                          input logic [31:0] stamp, input logic [7:0] flags,
                          input logic [7:0] avc, input int unsigned cut);
    int unsigned total;
    int unsigned hdr_len;
    int unsigned i;
    logic [7:0]  b;
    hdr_len = 32'(flvp_pkg::TAG_HDR_LEN);
    total = hdr_len + 32'(len) + 32'(flvp_pkg::TRAIL_LEN);
    for (i = 0; i < total && i < cut; i++) begin
      if (i < hdr_len) begin
        case (i)
          0: b = kind;
          1: b = len[23:16];
          2: b = len[15:8];
          3: b = len[7:0];
          4: b = stamp[23:16];
          5: b = stamp[15:8];
          6: b = stamp[7:0];
          7: b = stamp[31:24];
          default: b = 8'($urandom);
        endcase
      end else if (i == hdr_len && len != 0) begin
        b = flags;
      end else if (i == hdr_len + 1 && len > 1) begin
        b = avc;
      end else begin
        b = 8'($urandom);
      end
      push_byte(b, 1'b0);
    end
  endtask

  task automatic log_tag(input logic have_flags, input logic [7:0] flags,
                         input logic [7:0] avc);
    flvp_pkg::out_rec_t r;
    r = '0;
    tags_parsed = tags_parsed + 32'd1;
    r.tag_number = tags_parsed;
    r.tag_kind_code = cur_kind;
    r.payload_size = cur_len;
    r.time_stamp = cur_stamp;
    r.total_tag_size = {1'b0, cur_len} + {1'b0, flvp_pkg::TAG_HDR_LEN};
    if (cur_kind == flvp_pkg::TAG_AUDIO) r.media_kind = flvp_pkg::KIND_AUDIO;
    else if (cur_kind == flvp_pkg::TAG_VIDEO) r.media_kind = flvp_pkg::KIND_VIDEO;
    else r.media_kind = flvp_pkg::KIND_OTHER;
    if (have_flags && r.media_kind == flvp_pkg::KIND_AUDIO) begin
      r.codec_id = flags[7:4];
      r.audio_rate_code = flags[3:2];
      r.audio_sample_wide = flags[1];
      r.audio_stereo = flags[0];
    end else if (have_flags && r.media_kind == flvp_pkg::KIND_VIDEO) begin
      r.video_frame_type = flags[7:4];
      r.codec_id = flags[3:0];
    end
    r.avc_packet_type = avc;
    expected_records.push_back(r);
  endtask

  task automatic advance_parser(input logic [7:0] b, input logic restart);
    if (restart) begin
      parse_stage = STG_FILE_HDR;
      stage_count = '0;
      cur_kind = '0;
      cur_len = '0;
      cur_stamp = '0;
      cur_flags = '0;
      tags_parsed = '0;
    end
    case (parse_stage)
      STG_FILE_HDR: begin
        stage_count = stage_count + 24'd1;
        if (stage_count >= flvp_pkg::FILE_HDR_LEN) begin
          parse_stage = STG_TAG_HDR;
          stage_count = '0;
        end
      end
      STG_FLAGS: begin
        cur_flags = b;
        if (cur_kind == flvp_pkg::TAG_VIDEO && b[3:0] == flvp_pkg::CODEC_AVC &&
            cur_len >= 24'd2) begin
          parse_stage = STG_AVC;
        end else begin
          log_tag(1'b1, b, 8'd0);
          stage_count = cur_len - 24'd1;
          if (stage_count != 0) parse_stage = STG_SKIP;
          else parse_stage = STG_TRAILER;
        end
      end
      STG_AVC: begin
        log_tag(1'b1, cur_flags, b);
        stage_count = cur_len - 24'd2;
        if (stage_count != 0) parse_stage = STG_SKIP;
        else parse_stage = STG_TRAILER;
      end
      STG_SKIP: begin
        stage_count = stage_count - 24'd1;
        if (stage_count == 0) parse_stage = STG_TRAILER;
      end
      STG_TRAILER: begin
        stage_count = stage_count + 24'd1;
        if (stage_count >= flvp_pkg::TRAIL_LEN) begin
          parse_stage = STG_TAG_HDR;
          stage_count = '0;
        end
      end
      default: begin
        if (parse_stage != STG_TAG_HDR) begin
          parse_stage = STG_TAG_HDR;
          stage_count = '0;
        end
        case (stage_count)
          0: begin
            cur_kind = b;
            cur_len = '0;
            cur_stamp = '0;
            cur_flags = '0;
          end
          1: cur_len[23:16] = b;
          2: cur_len[15:8] = b;
          3: cur_len[7:0] = b;
          4: cur_stamp[23:16] = b;
          5: cur_stamp[15:8] = b;
          6: cur_stamp[7:0] = b;
          7: cur_stamp[31:24] = b;
          default: ;
        endcase
        stage_count = stage_count + 24'd1;
        if (stage_count >= flvp_pkg::TAG_HDR_LEN) begin
          stage_count = '0;
          if (cur_len == 0) begin
            log_tag(1'b0, 8'd0, 8'd0);
            parse_stage = STG_TRAILER;
          end else begin
            parse_stage = STG_FLAGS;
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch on tag %0d: expected %0h, got %0h",
               $time, field, head_record.tag_number, want, got);
      mismatches++;
    end
  endtask

  // driver: one transaction per handshake, gaps at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_parser(in_data_byte, in_stream_start);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (stimulus.size() != 0 && (calm || $urandom_range(0, 99) >= 17) &&
            !(stimulus[0].wait_drain && expected_records.size() != 0)) begin
          in_valid <= 1'b1;
          in_data_byte <= stimulus[0].data;
          in_stream_start <= stimulus[0].start;
          void'(stimulus.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted record with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_records.size() == 0) begin
          $display("%0t: unexpected record, expected none, got tag %0d",
                   $time, out_tag_number);
          mismatches++;
        end else begin
          head_record = expected_records.pop_front();
          check_field("tag_number", out_tag_number, head_record.tag_number);
          check_field("tag_kind_code", 32'(out_tag_kind_code),
                      32'(head_record.tag_kind_code));
          check_field("payload_size", 32'(out_payload_size),
                      32'(head_record.payload_size));
          check_field("time_stamp", out_time_stamp, head_record.time_stamp);
          check_field("total_tag_size", 32'(out_total_tag_size),
                      32'(head_record.total_tag_size));
          check_field("media_kind", 32'(out_media_kind), 32'(head_record.media_kind));
          check_field("codec_id", 32'(out_codec_id), 32'(head_record.codec_id));
          check_field("audio_rate_code", 32'(out_audio_rate_code),
                      32'(head_record.audio_rate_code));
          check_field("audio_sample_wide", 32'(out_audio_sample_wide),
                      32'(head_record.audio_sample_wide));
          check_field("audio_stereo", 32'(out_audio_stereo),
                      32'(head_record.audio_stereo));
          check_field("video_frame_type", 32'(out_video_frame_type),
                      32'(head_record.video_frame_type));
          check_field("avc_packet_type", 32'(out_avc_packet_type),
                      32'(head_record.avc_packet_type));
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 17);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int          plan_goal;
    int          roll;
    int          pick;
    logic [7:0]  kind;
    logic [23:0] len;
    logic [7:0]  flags;

    push_file_header();
    push_tag(flvp_pkg::TAG_AUDIO, 24'd0, 32'h0000_0000, 8'h00, 8'h00, WHOLE_TAG);
    push_tag(flvp_pkg::TAG_AUDIO, 24'd1, 32'hFFFF_FFFF, 8'hFF, 8'h00, WHOLE_TAG);
    push_tag(flvp_pkg::TAG_AUDIO, 24'd3, 32'h8000_0000, 8'h00, 8'hFF, WHOLE_TAG);
    push_tag(flvp_pkg::TAG_VIDEO, 24'd0, 32'h7FFF_FFFF, 8'h17, 8'h01, WHOLE_TAG);
    // AVC codec with a one-byte payload has no packet type byte
    push_tag(flvp_pkg::TAG_VIDEO, 24'd1, $urandom, 8'h17, 8'h00, WHOLE_TAG);
    push_tag(flvp_pkg::TAG_VIDEO, 24'd2, $urandom, 8'hF7, 8'hFF, WHOLE_TAG);
    push_tag(flvp_pkg::TAG_VIDEO, 24'd5, $urandom, 8'h27, 8'h00, WHOLE_TAG);
    push_tag(flvp_pkg::TAG_VIDEO, 24'd4, $urandom, 8'hF2, 8'h01, WHOLE_TAG);
    push_tag(TAG_SCRIPT, 24'd3, $urandom, 8'hAB, 8'hCD, WHOLE_TAG);
    push_tag(8'hFF, 24'd2, $urandom, 8'h5A, 8'hA5, WHOLE_TAG);
    push_tag(8'h00, 24'd1, $urandom, 8'hC3, 8'h00, WHOLE_TAG);
    // restart inside a tag header
    push_tag(flvp_pkg::TAG_AUDIO, 24'd6, $urandom, 8'h11, 8'h00, 5);
    push_file_header();
    // largest payloads, abandoned by a restart part way through
    push_tag(flvp_pkg::TAG_VIDEO, 24'hFF_FFFF, $urandom, 8'h17, 8'h02, 40);
    push_file_header();
    push_tag(flvp_pkg::TAG_AUDIO, 24'hFF_FFFF, $urandom, 8'h3C, 8'h00, 12);
    // restart inside the file header, then inside a trailer
    push_byte(8'($urandom), 1'b1);
    repeat (6) push_byte(8'($urandom), 1'b0);
    push_file_header();
    push_tag(flvp_pkg::TAG_AUDIO, 24'd2, $urandom, 8'h96, 8'h00, 15);
    push_file_header();

    // hold the random part until every directed record has come out
    hold_for_drain = 1'b1;
    plan_goal = stimulus.size() + RANDOM_BYTES;
    while (stimulus.size() < plan_goal) begin
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 9);
      if (pick < 4) kind = flvp_pkg::TAG_AUDIO;
      else if (pick < 8) kind = flvp_pkg::TAG_VIDEO;
      else if (pick < 9) kind = TAG_SCRIPT;
      else kind = 8'($urandom);
      pick = $urandom_range(0, 19);
      if (pick < 14) len = 24'($urandom_range(0, 4));
      else if (pick < 19) len = 24'($urandom_range(5, 40));
      else len = 24'($urandom_range(41, 300));
      flags = 8'($urandom);
      if (kind == flvp_pkg::TAG_VIDEO && $urandom_range(0, 1) == 1) begin
        flags[3:0] = flvp_pkg::CODEC_AVC;
      end
      if (roll < 86) begin
        push_tag(kind, len, $urandom, flags, 8'($urandom), WHOLE_TAG);
      end else if (roll < 94) begin
        // broken tag: cut short by a restart when the cut falls inside the tag
        if (roll < 90) len = 24'($urandom);
        push_tag(kind, len, $urandom, flags, 8'($urandom), $urandom_range(1, 30));
        push_file_header();
      end else begin
        push_file_header();
      end
    end
    bytes_planned = stimulus.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken != bytes_planned) @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
